// ===== src/sacrr_pkg.sv =====
package sacrr_pkg;

  localparam int ADDR_W = 32;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 32;

  localparam int SET_COUNT = 128;
  localparam int WAY_COUNT = 8;

  // replacement counter and victim mix
  localparam int RC_W  = 11;
  localparam int SQ_W  = 2 * RC_W;
  localparam int MIX_W = SQ_W + 1;
  localparam logic [RC_W-1:0]  COUNTER_STEP  = RC_W'(7);
  localparam logic [RC_W-1:0]  COUNTER_LIMIT = RC_W'(1543);
  localparam logic [MIX_W-1:0] MIX_OFFSET    = MIX_W'(422);

  // divide by three as multiply by 683 and shift by 11, exact for counter values up to 1543
  localparam int DIV3_SHIFT = 11;
  localparam logic [DIV3_SHIFT-1:0] DIV3_RECIP = DIV3_SHIFT'(683);

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
  } item_t;

endpackage

// ===== src/set_assoc_cache_random_replace.sv =====
// set-associative cache, SET_COUNT sets by WAY_COUNT ways, one 32-bit word per line
// in channel: in_cmd (0 read lookup, 1 write or miss fill), in_address, in_write_data;
//   a transfer happens on a rising edge with in_valid high and in_stall low
// out channel: one result per input transfer, in order: out_hit, out_read_data,
//   out_way_used, out_read_total, out_miss_total; same valid and stall rules
// a read miss reports no data; the fill comes back later as a write with the fetched word
// a full set is refilled at a pseudo-random way picked by the replacement counter
// timing: a two-entry queue takes transfers while the back end works; the back end reads
//   the set row into registers, then compares, writes back and registers the result
//   once the output register is free
// the back end takes one item at a time, reading and then, for a write, writing the single set memory
// reset: synchronous, active low; afterwards the back end clears the valid bits one set
//   per cycle through all SET_COUNT sets (128 by default), the queue still takes up to two items
// a stalled result holds in the output register; the back end then waits and the queue fills,
//   after which in_stall rises
module set_assoc_cache_random_replace import sacrr_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_cmd,
  input  logic [ADDR_W-1:0]            in_address,
  input  logic [DATA_W-1:0]            in_write_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_hit,
  output logic [DATA_W-1:0]            out_read_data,
  output logic [$clog2(WAY_COUNT)-1:0] out_way_used,
  output logic [CNT_W-1:0]             out_read_total,
  output logic [CNT_W-1:0]             out_miss_total
);

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  sacrr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_item        (q_item)
  );

  sacrr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_item         (q_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_read_data  (out_read_data),
    .out_way_used   (out_way_used),
    .out_read_total (out_read_total),
    .out_miss_total (out_miss_total)
  );

endmodule

// ===== src/sacrr_front.sv =====
module sacrr_front import sacrr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_cmd,
  input  logic [ADDR_W-1:0] in_address,
  input  logic [DATA_W-1:0] in_write_data,
  output logic              q_valid,
  input  logic              q_pop,
  output item_t             q_item
);

  localparam int Q_DEPTH = 2;
  localparam int QC_W    = $clog2(Q_DEPTH + 1);
  localparam int QP_W    = $clog2(Q_DEPTH);

  item_t            q_mem_r [Q_DEPTH];
  logic [QP_W-1:0]  wr_ptr_r;
  logic [QP_W-1:0]  rd_ptr_r;
  logic [QC_W-1:0]  count_r;
  item_t            item_in;
  logic             push;
  logic             pop;

  // classify the incoming transfer
  always_comb begin
    item_in.op      = in_cmd ? OP_WRITE : OP_READ;
    item_in.address = in_address;
    item_in.data    = in_write_data;
  end

  assign in_stall = (count_r == QC_W'(Q_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

// ===== src/sacrr_back.sv =====
module sacrr_back import sacrr_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  output logic                         q_pop,
  input  item_t                        q_item,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_hit,
  output logic [DATA_W-1:0]            out_read_data,
  output logic [$clog2(WAY_COUNT)-1:0] out_way_used,
  output logic [CNT_W-1:0]             out_read_total,
  output logic [CNT_W-1:0]             out_miss_total
);

  localparam int SET_W  = $clog2(SET_COUNT);
  localparam int WAY_W  = $clog2(WAY_COUNT);
  localparam int TAG_W  = ADDR_W - SET_W;
  localparam int PROD_W = RC_W + DIV3_SHIFT;

  typedef logic [WAY_COUNT-1:0]             valid_row_t;
  typedef logic [WAY_COUNT-1:0][TAG_W-1:0]  tag_row_t;
  typedef logic [WAY_COUNT-1:0][DATA_W-1:0] word_row_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  // set memory, one row per set
  valid_row_t mem_valid [SET_COUNT];
  tag_row_t   mem_tag   [SET_COUNT];
  word_row_t  mem_word  [SET_COUNT];

  state_t             state_r;
  logic [SET_W-1:0]   clr_addr_r;
  op_t                op_r;
  logic [SET_W-1:0]   set_r;
  logic [TAG_W-1:0]   tag_r;
  logic [DATA_W-1:0]  data_r;
  valid_row_t         rd_valid_r;
  tag_row_t           rd_tag_r;
  word_row_t          rd_word_r;
  logic [RC_W-1:0]    counter_r;
  logic [SQ_W-1:0]    sq_r;
  logic [RC_W-1:0]    div_r;
  logic [CNT_W-1:0]   reads_r;
  logic [CNT_W-1:0]   misses_r;
  logic               out_valid_r;
  logic               out_hit_r;
  logic [DATA_W-1:0]  out_read_data_r;
  logic [WAY_W-1:0]   out_way_r;

  logic                         rd_en;
  logic [SET_W-1:0]             rd_addr;
  logic                         mem_we;
  logic [SET_W-1:0]             wr_addr;
  valid_row_t                   wr_valid;
  tag_row_t                     wr_tag;
  word_row_t                    wr_word;
  valid_row_t                   new_valid;
  tag_row_t                     new_tag;
  word_row_t                    new_word;
  logic [WAY_COUNT-1:0]         match;
  logic                         hit;
  logic [WAY_W-1:0]             hit_way;
  logic [WAY_W-1:0]             free_way;
  logic                         has_free;
  logic [MIX_W-1:0]             mix;
  logic [WAY_W-1:0]             victim;
  logic [WAY_W-1:0]             fill_way;
  logic                         out_go;
  logic [RC_W:0]                cnt_sum;
  logic [RC_W:0]                cnt_wrap;
  logic [RC_W-1:0]              cnt_nxt;
  logic [PROD_W-1:0]            div_prod;
  logic [CNT_W-1:0]             reads_nxt;
  logic [CNT_W-1:0]             misses_nxt;

  assign rd_en   = (state_r == ST_IDLE) && q_valid;
  assign q_pop   = rd_en;
  assign rd_addr = q_item.address[SET_W-1:0];
  assign out_go  = (state_r == ST_LOOKUP) && (!out_valid_r || !out_stall);

  // tag compare and way selection
  always_comb begin
    match    = '0;
    hit_way  = '0;
    free_way = '0;
    for (int w = 0; w < WAY_COUNT; w++) begin
      match[w] = rd_valid_r[w] && (rd_tag_r[w] == tag_r);
    end
    for (int w = WAY_COUNT - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WAY_W'(w);
      end
      if (!rd_valid_r[w]) begin
        free_way = WAY_W'(w);
      end
    end
    hit      = |match;
    has_free = ~&rd_valid_r;
    mix      = MIX_W'(sq_r) + MIX_OFFSET + MIX_W'(div_r);
    victim   = mix[WAY_W-1:0];
    fill_way = has_free ? free_way : victim;
  end

  // updated row for a write
  always_comb begin
    new_valid = rd_valid_r;
    new_tag   = rd_tag_r;
    new_word  = rd_word_r;
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (match[w]) begin
        new_word[w] = data_r;
      end
    end
    if (!hit) begin
      new_valid[fill_way] = 1'b1;
      new_tag[fill_way]   = tag_r;
      new_word[fill_way]  = data_r;
    end
  end

  always_comb begin
    if (state_r == ST_CLEAR) begin
      mem_we   = 1'b1;
      wr_addr  = clr_addr_r;
      wr_valid = '0;
      wr_tag   = '0;
      wr_word  = '0;
    end else begin
      mem_we   = out_go && (op_r == OP_WRITE);
      wr_addr  = set_r;
      wr_valid = new_valid;
      wr_tag   = new_tag;
      wr_word  = new_word;
    end
  end

  // replacement counter step and victim terms
  always_comb begin
    cnt_sum    = {1'b0, counter_r} + {1'b0, COUNTER_STEP};
    cnt_wrap   = cnt_sum - {1'b0, COUNTER_LIMIT};
    cnt_nxt    = (cnt_sum > {1'b0, COUNTER_LIMIT}) ? cnt_wrap[RC_W-1:0] : cnt_sum[RC_W-1:0];
    div_prod   = PROD_W'(counter_r) * PROD_W'(DIV3_RECIP);
    reads_nxt  = reads_r + 1'b1;
    misses_nxt = misses_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    sq_r  <= SQ_W'(counter_r) * SQ_W'(counter_r);
    div_r <= div_prod[PROD_W-1:DIV3_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_valid[wr_addr] <= wr_valid;
      mem_tag[wr_addr]   <= wr_tag;
      mem_word[wr_addr]  <= wr_word;
    end
    if (rd_en) begin
      rd_valid_r <= mem_valid[rd_addr];
      rd_tag_r   <= mem_tag[rd_addr];
      rd_word_r  <= mem_word[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      counter_r   <= '0;
      reads_r     <= '0;
      misses_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == SET_W'(SET_COUNT - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_valid) begin
            state_r <= ST_LOOKUP;
            op_r    <= q_item.op;
            set_r   <= q_item.address[SET_W-1:0];
            tag_r   <= q_item.address[ADDR_W-1:SET_W];
            data_r  <= q_item.data;
          end
        end
        ST_LOOKUP: begin
          if (out_go) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      if (out_go) begin
        out_valid_r <= 1'b1;
        out_hit_r   <= hit;
        if (op_r == OP_READ) begin
          reads_r         <= reads_nxt;
          out_read_data_r <= hit ? rd_word_r[hit_way] : '0;
          out_way_r       <= hit ? hit_way : '0;
          if (!hit) begin
            misses_r <= misses_nxt;
          end
        end else begin
          counter_r       <= cnt_nxt;
          out_read_data_r <= '0;
          out_way_r       <= hit ? hit_way : fill_way;
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_data  = out_read_data_r;
  assign out_way_used   = out_way_r;
  assign out_read_total = reads_r;
  assign out_miss_total = misses_r;

endmodule

// ===== src/sacrr_checker.sv =====
module sacrr_checker import sacrr_pkg::*; (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_hit,
  input logic [DATA_W-1:0]            out_read_data,
  input logic [$clog2(WAY_COUNT)-1:0] out_way_used,
  input logic [CNT_W-1:0]             out_read_total,
  input logic [CNT_W-1:0]             out_miss_total
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hit) && $stable(out_read_data)
      && $stable(out_way_used) && $stable(out_read_total) && $stable(out_miss_total))
    else $error("result changed while stalled");

  // no data without a hit
  a_miss_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_read_data == '0)
    else $error("read data on a miss");

  // reset empties the output register
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // reset empties the queue
  a_reset_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind set_assoc_cache_random_replace sacrr_checker u_sacrr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_hit        (out_hit),
  .out_read_data  (out_read_data),
  .out_way_used   (out_way_used),
  .out_read_total (out_read_total),
  .out_miss_total (out_miss_total)
);
